### rtl/calcnt_pkg.sv
// ----------------------------------------------------------------------------
// calcnt_pkg
// Types, codes and calendar helpers for the calendar date counter.
// ----------------------------------------------------------------------------
package calcnt_pkg;

  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;

  localparam logic [YearW-1:0]  YEAR_MIN  = YearW'(1970);
  localparam logic [YearW-1:0]  YEAR_MAX  = YearW'(9999);
  localparam logic [MonthW-1:0] MONTH_DEC = MonthW'(12);

  typedef enum logic [0:0] {
    OP_SET     = 1'b0,
    OP_ADVANCE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_INVALID = 2'd1,
    STATUS_WRAP    = 2'd2
  } status_t;

  typedef struct packed {
    op_t               operation;
    logic [YearW-1:0]  new_year;
    logic [MonthW-1:0] new_month;
    logic [DayW-1:0]   new_day;
  } cal_in_t;

  typedef struct packed {
    logic [YearW-1:0]  year_now;
    logic [MonthW-1:0] month_now;
    logic [DayW-1:0]   day_now;
    status_t           status;
  } cal_out_t;

  localparam logic [DayW-1:0] MONTH_LEN [12] = '{
    DayW'(31), DayW'(28), DayW'(31), DayW'(30), DayW'(31), DayW'(30),
    DayW'(31), DayW'(31), DayW'(30), DayW'(31), DayW'(30), DayW'(31)
  };

  // Gregorian leap rule. year / 100 by reciprocal: exact below 43699.
  function automatic logic is_leap(input logic [YearW-1:0] year);
    logic [26:0] prod;
    logic [7:0]  cent;
    logic [14:0] back;
    logic        div100;
    prod   = 27'(year) * 27'(5243);
    cent   = prod[26:19];
    back   = 15'(cent) * 15'(100);
    div100 = (back == {1'b0, year});
    return (year[1:0] == 2'b00) && (!div100 || (cent[1:0] == 2'b00));
  endfunction

  // Month length; a month outside 1 to 12 counts as 31 days.
  function automatic logic [DayW-1:0] days_in(input logic [YearW-1:0] year,
                                              input logic [MonthW-1:0] month);
    logic [DayW-1:0] len;
    if (month == '0 || month > MONTH_DEC) begin
      len = DayW'(31);
    end else if (month == MonthW'(2) && is_leap(year)) begin
      len = DayW'(29);
    end else begin
      len = MONTH_LEN[month - MonthW'(1)];
    end
    return len;
  endfunction

endpackage

### rtl/calendar_date_counter_top.sv
// ----------------------------------------------------------------------------
// calendar_date_counter_top
// Gregorian date register with checked load and one-day advance.
// ----------------------------------------------------------------------------
//  channel | direction | payload   | handshake
//  --------+-----------+-----------+------------------------
//  in      | input     | cal_in_t  | in_valid / in_stall
//  out     | output    | cal_out_t | out_valid / out_stall
//
// One transaction per cycle while in_stall is low; each result is registered before it shows.
// The date update and the leap check sit in one stage ahead of the result register.
// A two-entry output queue (result register plus skid entry) keeps the input
// open while one result waits; in_stall rises only when both entries are full.
// Synchronous reset loads 1970-01-01 and empties the queue.
// ----------------------------------------------------------------------------
module calendar_date_counter_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  calcnt_pkg::cal_in_t in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output calcnt_pkg::cal_out_t out_data
);

  logic [calcnt_pkg::YearW-1:0]  current_year;
  logic [calcnt_pkg::MonthW-1:0] current_month;
  logic [calcnt_pkg::DayW-1:0]   current_day;

  logic [calcnt_pkg::YearW-1:0]  current_year_next;
  logic [calcnt_pkg::MonthW-1:0] current_month_next;
  logic [calcnt_pkg::DayW-1:0]   current_day_next;

  calcnt_pkg::cal_out_t result;
  calcnt_pkg::cal_out_t out_reg, out_reg_next;
  calcnt_pkg::cal_out_t skid, skid_next;
  logic                 out_full, out_full_next;
  logic                 skid_full, skid_full_next;

  logic push;
  logic pop;

  // set path
  logic [calcnt_pkg::DayW-1:0] set_len;
  logic                        set_bad;

  // advance path
  logic [calcnt_pkg::DayW-1:0]   cur_len;
  logic [calcnt_pkg::DayW:0]     adv_day;
  logic [calcnt_pkg::MonthW:0]   adv_month;
  logic [calcnt_pkg::YearW:0]    adv_year;

  assign in_stall  = skid_full;
  assign out_valid = out_full;
  assign out_data  = out_reg;
  assign push      = in_valid && !in_stall;
  assign pop       = out_full && !out_stall;

  assign set_len = calcnt_pkg::days_in(in_data.new_year, in_data.new_month);
  assign set_bad = (in_data.new_year < calcnt_pkg::YEAR_MIN) ||
                   (in_data.new_year > calcnt_pkg::YEAR_MAX) ||
                   (in_data.new_month == '0) ||
                   (in_data.new_month > calcnt_pkg::MONTH_DEC) ||
                   (in_data.new_day == '0) ||
                   (in_data.new_day > set_len);

  assign cur_len = calcnt_pkg::days_in(current_year, current_month);

  always_comb begin
    adv_day   = {1'b0, current_day} + (calcnt_pkg::DayW+1)'(1);
    adv_month = {1'b0, current_month};
    adv_year  = {1'b0, current_year};
    result.status = calcnt_pkg::STATUS_OK;

    if (in_data.operation == calcnt_pkg::OP_SET) begin
      if (set_bad) begin
        current_year_next  = calcnt_pkg::YEAR_MIN;
        current_month_next = calcnt_pkg::MonthW'(1);
        current_day_next   = calcnt_pkg::DayW'(1);
        result.status      = calcnt_pkg::STATUS_INVALID;
      end else begin
        current_year_next  = in_data.new_year;
        current_month_next = in_data.new_month;
        current_day_next   = in_data.new_day;
      end
    end else begin
      // carry day into month, month into year; wrap past 9999 to 1970-01-01
      if (adv_day > {1'b0, cur_len}) begin
        adv_day   = (calcnt_pkg::DayW+1)'(1);
        adv_month = adv_month + (calcnt_pkg::MonthW+1)'(1);
      end
      if (adv_month > {1'b0, calcnt_pkg::MONTH_DEC}) begin
        adv_month = (calcnt_pkg::MonthW+1)'(1);
        adv_day   = (calcnt_pkg::DayW+1)'(1);
        adv_year  = adv_year + (calcnt_pkg::YearW+1)'(1);
      end
      if (adv_year > {1'b0, calcnt_pkg::YEAR_MAX}) begin
        adv_year      = {1'b0, calcnt_pkg::YEAR_MIN};
        adv_month     = (calcnt_pkg::MonthW+1)'(1);
        adv_day       = (calcnt_pkg::DayW+1)'(1);
        result.status = calcnt_pkg::STATUS_WRAP;
      end
      current_year_next  = adv_year[calcnt_pkg::YearW-1:0];
      current_month_next = adv_month[calcnt_pkg::MonthW-1:0];
      current_day_next   = adv_day[calcnt_pkg::DayW-1:0];
    end

    result.year_now  = current_year_next;
    result.month_now = current_month_next;
    result.day_now   = current_day_next;
  end

  // two-entry output queue
  always_comb begin
    out_reg_next   = out_reg;
    out_full_next  = out_full;
    skid_next      = skid;
    skid_full_next = skid_full;

    if (pop) begin
      if (skid_full) begin
        out_reg_next   = skid;
        skid_full_next = 1'b0;
      end else begin
        out_full_next = 1'b0;
      end
    end

    if (push) begin
      if (!out_full_next) begin
        out_reg_next  = result;
        out_full_next = 1'b1;
      end else begin
        skid_next      = result;
        skid_full_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_year  <= calcnt_pkg::YEAR_MIN;
      current_month <= calcnt_pkg::MonthW'(1);
      current_day   <= calcnt_pkg::DayW'(1);
      out_full      <= 1'b0;
      skid_full     <= 1'b0;
    end else begin
      if (push) begin
        current_year  <= current_year_next;
        current_month <= current_month_next;
        current_day   <= current_day_next;
      end
      out_full  <= out_full_next;
      skid_full <= skid_full_next;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    out_reg <= out_reg_next;
    skid    <= skid_next;
  end

endmodule

### tb/calendar_date_counter_checker.sv
// ----------------------------------------------------------------------------
// calendar_date_counter_checker
// Watches both channels of the calendar date counter, keeps its own copy of
// the held date, predicts the result of every accepted transaction and
// compares each returned result, in order, field by field.
// ----------------------------------------------------------------------------
module calendar_date_counter_checker
  import calcnt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_stall,
  input  cal_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_stall,
  input  cal_out_t out_data,
  output int       fail_count,
  output int       dates_pending,
  output int       dates_checked,
  output int       invalid_loads,
  output int       year_wraps
);

  int unsigned held_year;
  int unsigned held_month;
  int unsigned held_day;
  cal_out_t    expected_dates[$];
  int          fails = 0;
  int          checked = 0;
  int          invalids = 0;
  int          wraps = 0;

  assign fail_count    = fails;
  assign dates_checked = checked;
  assign invalid_loads = invalids;
  assign year_wraps    = wraps;

  function automatic bit leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // Out-of-range months count as 31 days.
  function automatic int unsigned month_days(input int unsigned y, input int unsigned m);
    case (m)
      2:            return leap_year(y) ? 29 : 28;
      4, 6, 9, 11:  return 30;
      default:      return 31;
    endcase
  endfunction

  // Apply one transaction to the held date and return the result it yields.
  function automatic cal_out_t step_calendar(input cal_in_t item);
    cal_out_t    res;
    int unsigned y, m, d;
    status_t     st;
    st = STATUS_OK;
    if (item.operation == OP_SET) begin
      y = item.new_year;
      m = item.new_month;
      d = item.new_day;
      if (y < 1970 || y > 9999 || m < 1 || m > 12 || d < 1 || d > month_days(y, m)) begin
        y  = 1970;
        m  = 1;
        d  = 1;
        st = STATUS_INVALID;
      end
    end else begin
      y = held_year;
      m = held_month;
      d = held_day + 1;
      if (d > month_days(y, m)) begin
        d = 1;
        m = m + 1;
      end
      if (m > 12) begin
        m = 1;
        d = 1;
        y = y + 1;
      end
      if (y > 9999) begin
        y  = 1970;
        m  = 1;
        d  = 1;
        st = STATUS_WRAP;
      end
    end
    held_year      = y % (1 << YearW);
    held_month     = m % (1 << MonthW);
    held_day       = d % (1 << DayW);
    res.year_now   = YearW'(held_year);
    res.month_now  = MonthW'(held_month);
    res.day_now    = DayW'(held_day);
    res.status     = st;
    return res;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("%0t: calendar result mismatch on %s: got %0d, want %0d",
             $time, field, got, want);
    fails++;
  endtask

  always @(posedge clk) begin
    cal_out_t want;
    if (rst) begin
      held_year  = 1970;
      held_month = 1;
      held_day   = 1;
      expected_dates.delete();
    end else begin
      // Check the returned result before queueing a new one.
      if (out_valid && !out_stall) begin
        if (expected_dates.size() == 0) begin
          report_mismatch("unexpected result (nothing outstanding)", 1, 0);
        end else begin
          want = expected_dates.pop_front();
          checked++;
          if (out_data.year_now !== want.year_now)
            report_mismatch("year_now", out_data.year_now, want.year_now);
          if (out_data.month_now !== want.month_now)
            report_mismatch("month_now", out_data.month_now, want.month_now);
          if (out_data.day_now !== want.day_now)
            report_mismatch("day_now", out_data.day_now, want.day_now);
          if (out_data.status !== want.status)
            report_mismatch("status", out_data.status, want.status);
        end
      end
      if (in_valid && !in_stall) begin
        want = step_calendar(in_data);
        if (want.status == STATUS_INVALID) invalids++;
        if (want.status == STATUS_WRAP) wraps++;
        expected_dates.push_back(want);
      end
    end
    dates_pending <= expected_dates.size();
  end

endmodule

### tb/tb_calendar_date_counter_top.sv
// ----------------------------------------------------------------------------
// tb_calendar_date_counter_top
// Drives checked date loads and one-day advances into the calendar date
// counter with random idle cycles and output back-pressure; a checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_calendar_date_counter_top;
  import calcnt_pkg::*;

  localparam int DirectedItems = 25;
  localparam int RandomItems   = 425;
  localparam int InW           = $bits(cal_in_t);

  logic     clk = 1'b0;
  logic     rst;
  logic     in_valid;
  logic     in_stall;
  cal_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  cal_out_t out_data;
  logic     steady;

  int fail_count;
  int dates_pending;
  int dates_checked;
  int invalid_loads;
  int year_wraps;
  int sent = 0;

  always #5 clk = ~clk;

  calendar_date_counter_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  calendar_date_counter_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .dates_pending (dates_pending),
    .dates_checked (dates_checked),
    .invalid_loads (invalid_loads),
    .year_wraps    (year_wraps)
  );

  // Receiver back-pressure; hold off during the steady stretch.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !steady && ($urandom_range(99) < 31);
    end
  end

  function automatic cal_in_t set_item(input int unsigned y, input int unsigned m,
                                       input int unsigned d);
    cal_in_t item;
    item.operation = OP_SET;
    item.new_year  = YearW'(y);
    item.new_month = MonthW'(m);
    item.new_day   = DayW'(d);
    return item;
  endfunction

  // Date fields carry noise; the block must ignore them on an advance.
  function automatic cal_in_t advance_item();
    cal_in_t item;
    item.operation = OP_ADVANCE;
    item.new_year  = YearW'($urandom);
    item.new_month = MonthW'($urandom);
    item.new_day   = DayW'($urandom);
    return item;
  endfunction

  function automatic cal_in_t valid_set_item();
    int unsigned y, m, len;
    case ($urandom_range(4))
      0:       y = $urandom_range(1970, 1975);
      1:       y = $urandom_range(9995, 9999);
      2:       y = 100 * $urandom_range(20, 99);
      3:       y = 4 * $urandom_range(493, 2499);
      default: y = $urandom_range(1970, 9999);
    endcase
    m   = $urandom_range(1, 12);
    len = days_in(YearW'(y), MonthW'(m));
    // Favor month ends so the carries get exercised.
    if ($urandom_range(1))
      return set_item(y, m, len - $urandom_range(0, 2));
    return set_item(y, m, $urandom_range(1, len));
  endfunction

  function automatic cal_in_t invalid_set_item();
    int unsigned y, m, len;
    y = $urandom_range(1970, 9999);
    m = $urandom_range(1, 12);
    case ($urandom_range(3))
      0: begin
        y = $urandom_range(1) ? $urandom_range(0, 1969) : $urandom_range(10000, 16383);
        return set_item(y, m, $urandom_range(1, 28));
      end
      1: return set_item(y, $urandom_range(1) ? 0 : $urandom_range(13, 15),
                         $urandom_range(1, 31));
      2: return set_item(y, m, 0);
      default: begin
        case ($urandom_range(4))
          0:       m = 2;
          1:       m = 4;
          2:       m = 6;
          3:       m = 9;
          default: m = 11;
        endcase
        len = days_in(YearW'(y), MonthW'(m));
        return set_item(y, m, $urandom_range(len + 1, 31));
      end
    endcase
  endfunction

  task automatic put_item(input cal_in_t item);
    in_data  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    steady <= (sent >= 250) && (sent < 330);
    if (!steady && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
  endtask

  initial begin
    cal_in_t item;
    int      roll;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    in_data  <= '0;
    steady   <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset date, extremes, leap rules, carries, wrap, bad fields.
    put_item(advance_item());
    put_item(set_item(1970, 1, 1));
    put_item(set_item(9999, 12, 31));
    put_item(advance_item());
    put_item(set_item(2000, 2, 29));
    put_item(set_item(2100, 2, 29));
    put_item(set_item(2024, 2, 29));
    put_item(advance_item());
    put_item(set_item(2023, 2, 29));
    put_item(set_item(2023, 2, 28));
    put_item(advance_item());
    put_item(set_item(2024, 12, 31));
    put_item(advance_item());
    put_item(set_item(2000, 2, 28));
    put_item(advance_item());
    put_item(set_item(2020, 0, 10));
    put_item(set_item(2020, 13, 10));
    put_item(set_item(2020, 15, 31));
    put_item(set_item(2020, 5, 0));
    put_item(set_item(2020, 4, 31));
    put_item(set_item(2020, 1, 31));
    put_item(set_item(16383, 6, 15));
    put_item(set_item(1969, 12, 31));
    put_item(set_item(0, 0, 0));
    put_item(set_item(10000, 1, 1));

    // Hold the sender until every outstanding result is back.
    in_valid <= 1'b0;
    @(posedge clk);
    while (dates_pending != 0) @(posedge clk);

    // Random: a load followed by a run of advances.
    while (sent < DirectedItems + RandomItems) begin
      roll = $urandom_range(99);
      if (roll < 75)      item = valid_set_item();
      else if (roll < 90) item = invalid_set_item();
      else                item = cal_in_t'(InW'($urandom));
      put_item(item);
      roll = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
      repeat (roll) put_item(advance_item());
    end

    in_valid <= 1'b0;
    steady   <= 1'b0;
    @(posedge clk);
    while (dates_pending != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    $display("Sent %0d transactions, checked %0d results.", sent, dates_checked);
    $display("Covered %0d rejected loads and %0d year wraps past 9999.",
             invalid_loads, year_wraps);
    if (fail_count == 0) begin
      $display("tb_calendar_date_counter_top: PASS");
    end else begin
      $display("tb_calendar_date_counter_top: FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timed out with %0d results outstanding.", dates_pending);
    $display("tb_calendar_date_counter_top: FAIL");
    $finish;
  end

endmodule
